### rtl/paabb_pkg.sv
// Shared types, constants and saturating arithmetic for the AABB union accumulator.
package paabb_pkg;

   localparam int COORD_BITS     = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int AXES           = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   wide_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_SPHERE = 2'd0,
      KIND_QUAD   = 2'd1,
      KIND_BOX    = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      coord_type a_x;
      coord_type a_y;
      coord_type a_z;
      coord_type b_x;
      coord_type b_y;
      coord_type b_z;
      coord_type c_x;
      coord_type c_y;
      coord_type c_z;
      logic      last;
   } req_type;

   typedef struct packed {
      coord_type min_x;
      coord_type min_y;
      coord_type min_z;
      coord_type max_x;
      coord_type max_y;
      coord_type max_z;
   } rsp_type;

   // classified item between front and back; per-axis candidate points
   typedef struct packed {
      logic                       add;
      logic                       last;
      logic                       quad;
      coord_type [AXES-1:0]       pa;
      coord_type [AXES-1:0]       pb;
      coord_type [AXES-1:0]       pc;
      coord_type [AXES-1:0]       vc;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic coord_type saturate(input wide_type s);
      coord_type r;
      if (s[COORD_BITS] != s[COORD_BITS-1]) begin
         r = s[COORD_BITS] ? COORD_MIN : COORD_MAX;
      end else begin
         r = coord_type'(s[COORD_BITS-1:0]);
      end
      return r;
   endfunction

   function automatic coord_type sat_add(input coord_type x, input coord_type y);
      wide_type s;
      s = wide_type'(x) + wide_type'(y);
      return saturate(s);
   endfunction

   function automatic coord_type sat_sub(input coord_type x, input coord_type y);
      wide_type s;
      s = wide_type'(x) - wide_type'(y);
      return saturate(s);
   endfunction

   function automatic coord_type cmin(input coord_type x, input coord_type y);
      return (x < y) ? x : y;
   endfunction

   function automatic coord_type cmax(input coord_type x, input coord_type y);
      return (x > y) ? x : y;
   endfunction

endpackage

### rtl/paabb_front.sv
// Front end: accepts primitives, decodes the kind and forms the first-level corner sums.
module paabb_front (
   input  paabb_pkg::req_type         req_item,
   input  logic                       req_push,
   input  paabb_pkg::fifo_status_type q_status,
   output logic                       req_full,
   output logic                       q_wr,
   output paabb_pkg::work_type        q_item
);
   import paabb_pkg::*;

   coord_type a [AXES];
   coord_type b [AXES];
   coord_type c [AXES];

   assign req_full = q_status.full;
   assign q_wr     = req_push && !q_status.full;

   always_comb begin
      a[0] = req_item.a_x;
      a[1] = req_item.a_y;
      a[2] = req_item.a_z;
      b[0] = req_item.b_x;
      b[1] = req_item.b_y;
      b[2] = req_item.b_z;
      c[0] = req_item.c_x;
      c[1] = req_item.c_y;
      c[2] = req_item.c_z;

      q_item.add  = (req_item.kind != KIND_NONE);
      q_item.quad = (req_item.kind == KIND_QUAD);
      q_item.last = req_item.last;

      for (int i = 0; i < AXES; i++) begin
         q_item.pa[i] = a[i];
         q_item.vc[i] = c[i];
         unique case (req_item.kind)
            KIND_SPHERE: begin
               // center +/- radius, exact then clamped; covers negative radius too
               q_item.pb[i] = sat_add(a[i], req_item.b_x);
               q_item.pc[i] = sat_sub(a[i], req_item.b_x);
            end
            KIND_QUAD: begin
               q_item.pb[i] = sat_add(a[i], b[i]);
               q_item.pc[i] = sat_add(a[i], c[i]);
            end
            KIND_BOX: begin
               q_item.pb[i] = b[i];
               q_item.pc[i] = a[i];
            end
            default: begin
               q_item.pb[i] = a[i];
               q_item.pc[i] = a[i];
            end
         endcase
      end
   end

endmodule

### rtl/paabb_queue.sv
// Short item queue that decouples the front end from the accumulate back end.
module paabb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr,
   input  paabb_pkg::work_type        wr_item,
   input  logic                       rd,
   output paabb_pkg::work_type        rd_item,
   output paabb_pkg::fifo_status_type status
);
   import paabb_pkg::*;

   work_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   localparam logic [QUEUE_PTR_BITS-1:0] PTR_LAST = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_PTR_BITS:0]   COUNT_FULL = (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);

   assign status.full  = (count_ff == COUNT_FULL);
   assign status.empty = (count_ff == '0);
   assign rd_item      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### rtl/paabb_back.sv
// Back end: per-item extents, running union box and the result register.
module paabb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  paabb_pkg::fifo_status_type q_status,
   input  paabb_pkg::work_type        q_item,
   output logic                       q_rd,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output paabb_pkg::rsp_type         rsp_item
);
   import paabb_pkg::*;

   // stage 1: extents of one item
   logic      s1_valid_ff, s1_valid_in;
   logic      s1_add_ff;
   logic      s1_last_ff;
   coord_type s1_lo_ff [AXES];
   coord_type s1_hi_ff [AXES];
   coord_type item_lo  [AXES];
   coord_type item_hi  [AXES];

   // stage 2: running box
   coord_type low_ff   [AXES];
   coord_type high_ff  [AXES];
   coord_type merged_lo [AXES];
   coord_type merged_hi [AXES];

   logic      out_valid_ff, out_valid_in;
   rsp_type   out_ff;

   logic      s1_fire;
   logic      s1_load;
   logic      out_taken;

   assign out_taken = rsp_pop && out_valid_ff;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_pop);
   assign s1_load   = !s1_valid_ff || s1_fire;
   assign q_rd      = s1_load && !q_status.empty;

   always_comb begin
      coord_type pd;
      for (int i = 0; i < AXES; i++) begin
         // far quad corner: (corner+u) then +v
         pd = q_item.quad ? sat_add(q_item.pb[i], q_item.vc[i]) : q_item.pc[i];
         item_lo[i] = cmin(cmin(q_item.pa[i], q_item.pb[i]), cmin(q_item.pc[i], pd));
         item_hi[i] = cmax(cmax(q_item.pa[i], q_item.pb[i]), cmax(q_item.pc[i], pd));
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         merged_lo[i] = s1_add_ff ? cmin(low_ff[i], s1_lo_ff[i]) : low_ff[i];
         merged_hi[i] = s1_add_ff ? cmax(high_ff[i], s1_hi_ff[i]) : high_ff[i];
      end
      s1_valid_in = s1_load ? !q_status.empty : s1_valid_ff;
      if (s1_fire && s1_last_ff) begin
         out_valid_in = 1'b1;
      end else if (out_taken) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_rd) begin
         s1_add_ff  <= q_item.add;
         s1_last_ff <= q_item.last;
         for (int i = 0; i < AXES; i++) begin
            s1_lo_ff[i] <= item_lo[i];
            s1_hi_ff[i] <= item_hi[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            low_ff[i]  <= COORD_MAX;
            high_ff[i] <= COORD_MIN;
         end
      end else if (s1_fire) begin
         for (int i = 0; i < AXES; i++) begin
            low_ff[i]  <= s1_last_ff ? COORD_MAX : merged_lo[i];
            high_ff[i] <= s1_last_ff ? COORD_MIN : merged_hi[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         out_ff.min_x <= merged_lo[0];
         out_ff.min_y <= merged_lo[1];
         out_ff.min_z <= merged_lo[2];
         out_ff.max_x <= merged_hi[0];
         out_ff.max_y <= merged_hi[1];
         out_ff.max_z <= merged_hi[2];
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

### rtl/primitive_aabb_accumulator_core.sv
// Top level of the primitive AABB union accumulator.
//
// Streams scene primitives (sphere, quad, box; kind three is skipped) and keeps a running
// axis-aligned bounding box in signed Q16.16, with all corner sums saturating. The item
// flagged last is merged first, then the union box is offered on the rsp_ side and the
// running box returns to empty (min at the most positive value, max at the most negative).
// Throughput is one item per clock unless a held result stalls a last item: the front
// end decodes and forms the first corner sums as an item is pushed, a four-entry queue
// holds classified items, and the back end forms the far quad corner and the per-item
// extents in one stage and folds them into the running box in the next, so that fold is
// the only loop. A taken last item passes the queue and stage one before rsp_empty drops.
// One result register sits on the output; while it is still held, a further last item
// waits in the back end, items behind it fill the queue, and req_full rises only once
// the queue is full. No reset sweep: the block takes items as soon as reset is released.
module primitive_aabb_accumulator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  paabb_pkg::req_type req_item,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output paabb_pkg::rsp_type rsp_item
);
   import paabb_pkg::*;

   fifo_status_type q_status;
   work_type        q_wr_item;
   work_type        q_rd_item;
   logic            q_wr;
   logic            q_rd;

   // decode and first-level sums
   paabb_front u_front (
      .req_item (req_item),
      .req_push (req_push),
      .q_status (q_status),
      .req_full (req_full),
      .q_wr     (q_wr),
      .q_item   (q_wr_item)
   );

   // decoupling queue
   paabb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_item (q_wr_item),
      .rd      (q_rd),
      .rd_item (q_rd_item),
      .status  (q_status)
   );

   // extents, running box, result register
   paabb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_item    (q_rd_item),
      .q_rd      (q_rd),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   // queue occupancy can't be both full and empty
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   // back end reads only a non-empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_rd |-> !q_status.empty)
      else $error("queue read while empty");

   // after reset: no result pending and room for items
   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("bad state after reset");

endmodule

### bench/aabb_union_checker.sv
// Checker for the AABB union accumulator: tracks the running box from pushed items and compares popped boxes.
module aabb_union_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  paabb_pkg::req_type req_item,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  paabb_pkg::rsp_type rsp_item,
   output int                 failures,
   output int                 outstanding
);
   import paabb_pkg::*;

   coord_type box_lo [AXES];
   coord_type box_hi [AXES];
   rsp_type   boxes_due [$];
   int        fail_count = 0;
   int        due_count = 0;

   assign failures    = fail_count;
   assign outstanding = due_count;

   function automatic coord_type clip(input longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(v);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] aabb mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_coord(input string field, input coord_type got, input coord_type want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
      end
   endtask

   task automatic empty_box();
      for (int i = 0; i < AXES; i++) begin
         box_lo[i] = COORD_MAX;
         box_hi[i] = COORD_MIN;
      end
   endtask

   task automatic take_point(input int axis, input coord_type p);
      if (p < box_lo[axis]) box_lo[axis] = p;
      if (p > box_hi[axis]) box_hi[axis] = p;
   endtask

   task automatic merge_primitive(input req_type p);
      coord_type corner [AXES];
      coord_type u_vec [AXES];
      coord_type v_vec [AXES];
      coord_type near_u;
      coord_type near_v;
      coord_type far_uv;
      longint    radius;
      corner = '{p.a_x, p.a_y, p.a_z};
      u_vec  = '{p.b_x, p.b_y, p.b_z};
      v_vec  = '{p.c_x, p.c_y, p.c_z};
      radius = longint'(p.b_x);
      for (int i = 0; i < AXES; i++) begin
         case (p.kind)
            KIND_SPHERE: begin
               // sign of the radius does not matter, both ends are taken
               take_point(i, corner[i]);
               take_point(i, clip(longint'(corner[i]) - radius));
               take_point(i, clip(longint'(corner[i]) + radius));
            end
            KIND_QUAD: begin
               near_u = clip(longint'(corner[i]) + longint'(u_vec[i]));
               near_v = clip(longint'(corner[i]) + longint'(v_vec[i]));
               // far corner saturates after each add
               far_uv = clip(longint'(near_u) + longint'(v_vec[i]));
               take_point(i, corner[i]);
               take_point(i, near_u);
               take_point(i, near_v);
               take_point(i, far_uv);
            end
            KIND_BOX: begin
               take_point(i, corner[i]);
               take_point(i, u_vec[i]);
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         boxes_due.delete();
         empty_box();
         due_count <= 0;
      end else begin
         // a box popped here cannot stem from the item taken at this edge
         if (rsp_pop && !rsp_empty) begin
            if (boxes_due.size() == 0) begin
               report_mismatch($sformatf("box (%0d,%0d,%0d)..(%0d,%0d,%0d) with none due",
                  rsp_item.min_x, rsp_item.min_y, rsp_item.min_z,
                  rsp_item.max_x, rsp_item.max_y, rsp_item.max_z));
            end else begin
               want = boxes_due.pop_front();
               check_coord("min_x", rsp_item.min_x, want.min_x);
               check_coord("min_y", rsp_item.min_y, want.min_y);
               check_coord("min_z", rsp_item.min_z, want.min_z);
               check_coord("max_x", rsp_item.max_x, want.max_x);
               check_coord("max_y", rsp_item.max_y, want.max_y);
               check_coord("max_z", rsp_item.max_z, want.max_z);
            end
         end
         if (req_push && !req_full) begin
            merge_primitive(req_item);
            if (req_item.last) begin
               boxes_due.push_back(rsp_type'{min_x: box_lo[0], min_y: box_lo[1],
                                             min_z: box_lo[2], max_x: box_hi[0],
                                             max_y: box_hi[1], max_z: box_hi[2]});
               empty_box();
            end
         end
         due_count <= boxes_due.size();
      end
   end

endmodule

### bench/primitive_aabb_accumulator_core_tb.sv
// Testbench top for the AABB union accumulator: stimulus, handshakes, timeout and verdict.
module primitive_aabb_accumulator_core_tb;
   import paabb_pkg::*;

   // Items sent in the random part, kind three noise included.
   localparam int TARGET_ITEMS = 1750;
   // The last stretch of items runs with no idling on either side.
   localparam int CALM_ITEMS   = 150;
   // Slowest legal run is roughly 2000 items, each with the longest send gap and the
   // longest pop stall; the limit leaves a wide margin over that.
   localparam int CYCLE_LIMIT  = 400000;
   // Drain time after the final wait, to catch stray output.
   localparam int DRAIN_CYCLES = 8;
   localparam coord_type UNIT  = 32'sh0001_0000;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_item;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_item;

   int   failures;
   int   outstanding;
   int   cycle_count = 0;
   int   real_items = 0;
   logic calm = 1'b0;

   primitive_aabb_accumulator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   aabb_union_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_item    (req_item),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_item    (rsp_item),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("primitive_aabb_accumulator_core verification failed");
         $finish;
      end
   end

   // Coordinate mix: fully random words, small values around the origin, values
   // near either end of the range (to hit saturation) and the exact corner values.
   function automatic coord_type rand_coord();
      coord_type v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom;
         2: v = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
         3: v = COORD_MAX - $urandom_range(0, 1000);
         4: v = COORD_MIN + $urandom_range(0, 1000);
         default: begin
            case ($urandom_range(0, 4))
               0: v = '0;
               1: v = '1;
               2: v = 1;
               3: v = COORD_MAX;
               default: v = COORD_MIN;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic req_type prim(input kind_type k,
                                    input coord_type ax, ay, az, bx, by, bz, cx, cy, cz,
                                    input logic lst);
      req_type p;
      p.kind = k;
      p.a_x  = ax;
      p.a_y  = ay;
      p.a_z  = az;
      p.b_x  = bx;
      p.b_y  = by;
      p.b_z  = bz;
      p.c_x  = cx;
      p.c_y  = cy;
      p.c_z  = cz;
      p.last = lst;
      return p;
   endfunction

   // Kind three shows up about one time in ten as noise inside a range.
   function automatic req_type random_primitive();
      kind_type k;
      int       pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) k = KIND_SPHERE;
      else if (pick < 6) k = KIND_QUAD;
      else if (pick < 9) k = KIND_BOX;
      else k = KIND_NONE;
      return prim(k, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0);
   endfunction

   // Present one item and hold it until the block takes it. An optional idle
   // burst comes first so gaps land anywhere inside a range.
   task automatic send_item(input req_type item);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 8);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (req_full);
      real_items++;
      if (real_items >= TARGET_ITEMS - CALM_ITEMS) calm <= 1'b1;
   endtask

   // Hold off the sender until every box already owed has been popped.
   task automatic wait_for_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Result side: pops most cycles, with random stall bursts in between.
   initial begin : pop_side
      int stall;
      stall = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 8) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      req_type item;
      int      span;
      logic    paused;
      paused = 1'b0;
      reset    <= 1'b1;
      req_push <= 1'b0;
      req_item <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty range straight out of reset: kind three with last set.
      send_item(prim(KIND_NONE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     1'b1));
      // Plain sphere, then a negative radius with junk in the unused fields.
      send_item(prim(KIND_SPHERE, UNIT, -2 * UNIT, 0, 3 * UNIT, 0, 0, 0, 0, 0, 1'b1));
      send_item(prim(KIND_SPHERE, 0, UNIT, -UNIT, -5 * UNIT, rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), 1'b1));
      // Sphere sums that saturate both ways, and the most negative radius.
      send_item(prim(KIND_SPHERE, COORD_MAX, COORD_MIN, 0, COORD_MAX, 0, 0, 0, 0, 0, 1'b1));
      send_item(prim(KIND_SPHERE, 0, COORD_MAX, COORD_MIN, COORD_MIN, 0, 0, 0, 0, 0, 1'b1));
      // Quad whose near corner saturates before the v edge pulls it back.
      send_item(prim(KIND_QUAD, COORD_MAX - 1, COORD_MIN + 1, 0, 10, -10, COORD_MAX,
                     -20, 20, COORD_MAX, 1'b1));
      // Two quads in one range, one pinned at the bottom of the range.
      send_item(prim(KIND_QUAD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                     COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
      send_item(prim(KIND_QUAD, UNIT, UNIT, UNIT, -UNIT, 2 * UNIT, 0, 0, -3 * UNIT, UNIT,
                     1'b1));
      // Reversed box corners, full range box, kind three noise, small box.
      send_item(prim(KIND_BOX, 5 * UNIT, 5 * UNIT, 5 * UNIT, -5 * UNIT, -5 * UNIT,
                     -5 * UNIT, rand_coord(), rand_coord(), rand_coord(), 1'b0));
      send_item(prim(KIND_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                     COORD_MAX, 0, 0, 0, 1'b0));
      send_item(prim(KIND_NONE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                     COORD_MIN, '1, '1, '1, 1'b0));
      send_item(prim(KIND_BOX, -UNIT, 0, UNIT, UNIT, 0, -UNIT, 0, 0, 0, 1'b1));
      // Range made only of kind three items still gives the empty box.
      send_item(prim(KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_item(prim(KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      // Degenerate shapes: point box, zero radius, zero quad edges.
      send_item(prim(KIND_BOX, 7, -7, 0, 7, -7, 0, 0, 0, 0, 1'b1));
      send_item(prim(KIND_SPHERE, -3, 3, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_item(prim(KIND_QUAD, 9, 9, 9, 0, 0, 0, 0, 0, 0, 1'b1));
      // One fully random item of each kind, each closing its own range.
      send_item(prim(KIND_SPHERE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, 1'b1));
      send_item(prim(KIND_QUAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, 1'b1));
      send_item(prim(KIND_BOX, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, 1'b1));
      send_item(prim(KIND_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, 1'b1));

      // Random ranges: mostly short, now and then a long one.
      real_items = 0;
      while (real_items < TARGET_ITEMS) begin
         span = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         for (int n = 0; n < span; n++) begin
            item      = random_primitive();
            item.last = (n == span - 1);
            send_item(item);
         end
         // One full drain partway through, with the sender held off.
         if (!paused && real_items >= TARGET_ITEMS / 3) begin
            paused = 1'b1;
            wait_for_results();
         end
      end

      // Every range was closed, so everything owed is in the checker's queue.
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("primitive_aabb_accumulator_core verification clean");
      end else begin
         $display("primitive_aabb_accumulator_core verification failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/paabb_pkg.sv
rtl/paabb_front.sv
rtl/paabb_queue.sv
rtl/paabb_back.sv
rtl/primitive_aabb_accumulator_core.sv
bench/aabb_union_checker.sv
bench/primitive_aabb_accumulator_core_tb.sv
